FILE: rtl/plx_pkg.sv
// ----------------------------------------------------------------------------
// plx_pkg: shared types and helpers of the lexer
// Token and token-group types, token kind codes, saturation helper.
// ----------------------------------------------------------------------------
package plx_pkg;

	// token kind codes
	localparam logic [3:0] KIND_EOF      = 4'd0;
	localparam logic [3:0] KIND_DEFINE   = 4'd1;
	localparam logic [3:0] KIND_COLON    = 4'd2;
	localparam logic [3:0] KIND_LPAREN   = 4'd3;
	localparam logic [3:0] KIND_RPAREN   = 4'd4;
	localparam logic [3:0] KIND_LBRACKET = 4'd5;
	localparam logic [3:0] KIND_RBRACKET = 4'd6;
	localparam logic [3:0] KIND_LBRACE   = 4'd7;
	localparam logic [3:0] KIND_RBRACE   = 4'd8;
	localparam logic [3:0] KIND_ARROW    = 4'd9;
	localparam logic [3:0] KIND_IDENT    = 4'd10;
	localparam logic [3:0] KIND_ERROR    = 4'd11;

	// most tokens one byte can produce
	localparam int MAX_TOKENS = 3;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
	} token_t;

	// all tokens caused by one byte, oldest in slot 0
	typedef struct packed {
		logic [1:0]                  count;
		token_t [MAX_TOKENS-1:0]     tok;
	} bundle_t;

	function automatic logic [15:0] clip16(input logic [31:0] x);
		return (x > 32'h0000_FFFF) ? 16'hFFFF : x[15:0];
	endfunction

	function automatic token_t mk_tok(input logic [3:0] kind, input logic [31:0] start,
			input logic [31:0] length);
		token_t t;
		t.kind   = kind;
		t.start  = clip16(start);
		t.length = clip16(length);
		return t;
	endfunction

endpackage

FILE: rtl/plx_front.sv
// ----------------------------------------------------------------------------
// plx_front: byte scanner
// One byte a cycle unless q_full; tracks pending tokens, builds token groups.
// ----------------------------------------------------------------------------
module plx_front import plx_pkg::*; #(
	parameter int POSITION_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [7:0]    text_byte,
	input  logic          final_byte,
	input  logic          q_full,
	output logic          q_push,
	output bundle_t       q_data
);

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_COLON,
		MODE_MINUS,
		MODE_IDENT,
		MODE_DROP
	} mode_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_US    = 8'h5F;

	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

	mode_t                     mode_q, mode_d;
	logic [POSITION_BITS-1:0]  pos_q, pos_d;
	logic [POSITION_BITS-1:0]  pstart_q, pstart_d;
	logic [POSITION_BITS-1:0]  plen_q, plen_d;

	logic                      accept;
	logic                      used;
	logic                      dropped;
	logic [1:0]                n;
	token_t [MAX_TOKENS-1:0]   tok;
	logic                      is_space;
	logic                      is_alpha;
	logic                      is_word;
	logic [3:0]                bk;

	function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] x);
		return (x == POS_MAX) ? x : x + 1'b1;
	endfunction

	assign accept = push && !q_full;

	always_comb begin
		is_space = text_byte inside {CH_SPACE, CH_TAB, CH_NL};
		is_alpha = text_byte inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_US};
		is_word  = is_alpha || (text_byte inside {[8'h30:8'h39]});
		case (text_byte)
			8'h28:   bk = KIND_LPAREN;
			8'h29:   bk = KIND_RPAREN;
			8'h5B:   bk = KIND_LBRACKET;
			8'h5D:   bk = KIND_RBRACKET;
			8'h7B:   bk = KIND_LBRACE;
			8'h7D:   bk = KIND_RBRACE;
			default: bk = KIND_EOF;
		endcase
	end

	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		pstart_d = pstart_q;
		plen_d   = plen_q;
		used     = 1'b0;
		dropped  = 1'b0;
		n        = 2'd0;
		tok      = '0;
		if (accept) begin
			if (mode_q == MODE_DROP) begin
				if (final_byte) begin
					mode_d   = MODE_IDLE;
					pos_d    = '0;
					pstart_d = '0;
					plen_d   = '0;
				end else begin
					pos_d = sat_inc(pos_q);
				end
			end else begin
				// finish what the previous bytes left pending
				case (mode_q)
					MODE_COLON: begin
						if (text_byte == CH_EQ) begin
							tok[n] = mk_tok(KIND_DEFINE, 32'(pstart_q), 32'd2);
							used   = 1'b1;
						end else begin
							tok[n] = mk_tok(KIND_COLON, 32'(pstart_q), 32'd1);
						end
						n      = n + 2'd1;
						mode_d = MODE_IDLE;
					end
					MODE_MINUS: begin
						if (text_byte == CH_GT) begin
							tok[n] = mk_tok(KIND_ARROW, 32'(pstart_q), 32'd2);
							mode_d = MODE_IDLE;
						end else begin
							tok[n] = mk_tok(KIND_ERROR, 32'(pstart_q), 32'd1);
							mode_d = MODE_DROP;
						end
						n    = n + 2'd1;
						used = 1'b1;
					end
					MODE_IDENT: begin
						if (is_word) begin
							plen_d = sat_inc(plen_q);
							used   = 1'b1;
						end else begin
							tok[n] = mk_tok(KIND_IDENT, 32'(pstart_q), 32'(plen_q));
							n      = n + 2'd1;
							mode_d = MODE_IDLE;
						end
					end
					default: ;
				endcase

				// byte starts something new
				if (!used) begin
					if (is_space) begin
						mode_d = mode_d;
					end else if (text_byte == CH_COLON) begin
						mode_d   = MODE_COLON;
						pstart_d = pos_q;
					end else if (text_byte == CH_MINUS) begin
						mode_d   = MODE_MINUS;
						pstart_d = pos_q;
					end else if (bk != KIND_EOF) begin
						tok[n] = mk_tok(bk, 32'(pos_q), 32'd1);
						n      = n + 2'd1;
					end else if (is_alpha) begin
						mode_d   = MODE_IDENT;
						pstart_d = pos_q;
						plen_d   = POSITION_BITS'(1);
					end else begin
						tok[n] = mk_tok(KIND_ERROR, 32'(pos_q), 32'd1);
						n      = n + 2'd1;
						mode_d = MODE_DROP;
					end
				end

				// end of text flushes the pending token and adds eof unless an error ends it
				if (final_byte) begin
					dropped = (mode_d == MODE_DROP);
					case (mode_d)
						MODE_COLON: begin
							tok[n] = mk_tok(KIND_COLON, 32'(pstart_d), 32'd1);
							n      = n + 2'd1;
						end
						MODE_MINUS: begin
							tok[n]  = mk_tok(KIND_ERROR, 32'(pstart_d), 32'd1);
							n       = n + 2'd1;
							dropped = 1'b1;
						end
						MODE_IDENT: begin
							tok[n] = mk_tok(KIND_IDENT, 32'(pstart_d), 32'(plen_d));
							n      = n + 2'd1;
						end
						default: ;
					endcase
					if (!dropped) begin
						tok[n] = mk_tok(KIND_EOF, 32'(sat_inc(pos_q)), 32'd0);
						n      = n + 2'd1;
					end
					mode_d   = MODE_IDLE;
					pos_d    = '0;
					pstart_d = '0;
					plen_d   = '0;
				end else begin
					pos_d = sat_inc(pos_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			pstart_q <= '0;
			plen_q   <= '0;
		end else begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			pstart_q <= pstart_d;
			plen_q   <= plen_d;
		end
	end

	assign q_push       = accept && (n != 2'd0);
	assign q_data.count = n;
	assign q_data.tok   = tok;

endmodule

FILE: rtl/plx_queue.sv
// ----------------------------------------------------------------------------
// plx_queue: two-entry token group queue
// Decouples the byte scanner from the token sender.
// ----------------------------------------------------------------------------
module plx_queue import plx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t wr_data,
	output logic    full,
	input  logic    pop,
	output bundle_t rd_data,
	output logic    empty
);

	bundle_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_wr   = push && !full;
	assign do_rd   = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= !wr_ptr_q;
			if (do_rd) rd_ptr_q <= !rd_ptr_q;
			if (do_wr && !do_rd) count_q <= count_q + 2'd1;
			else if (do_rd && !do_wr) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

FILE: rtl/plx_back.sv
// ----------------------------------------------------------------------------
// plx_back: token sender
// Holds one token group and hands its tokens out one request at a time.
// ----------------------------------------------------------------------------
module plx_back import plx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bundle_t     q_data,
	input  logic        q_empty,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic        run_end
);

	logic       valid_q;
	bundle_t    group_q;
	logic [1:0] idx_q;
	logic       last;
	logic       take;
	token_t     cur;

	assign last  = (idx_q == group_q.count - 2'd1);
	// load a new group when the register is free or its last token leaves
	assign take  = !valid_q || (pop && last);
	assign q_pop = take && !q_empty;
	assign empty = !valid_q;

	assign cur          = group_q.tok[idx_q];
	assign token_kind   = cur.kind;
	assign token_start  = cur.start;
	assign token_length = cur.length;
	assign run_end      = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (take) begin
			valid_q <= !q_empty;
			idx_q   <= 2'd0;
		end else if (pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) group_q <= q_data;
	end

endmodule

FILE: rtl/punctuation_and_identifier_lexer.sv
// ----------------------------------------------------------------------------
// punctuation_and_identifier_lexer: streaming lexer for brackets, colon,
// define, arrow and identifiers
// Scans text one byte a cycle while full is low; delivers tokens with position and length.
// ----------------------------------------------------------------------------
// usage
//   input channel: text_byte and final_byte are taken on an edge with push high
//   and full low; final_byte marks the last byte of one text
//   result channel: while empty is low the oldest token sits on token_kind,
//   token_start, token_length and run_end; pop high takes it
//   run_end flags the last token caused by a given byte
// path and throughput
//   the tokens of a byte are written to the queue at the taking edge and
//   loaded from there into the sender once it is free or its last token leaves
//   one byte per cycle while pop is high and bytes give at most one token each;
//   a byte that gives two or three tokens holds the sender until each is popped,
//   and the two-entry queue absorbs that until it fills
// reset
//   arst_n clears the scanner to idle with position zero and empties queue
//   and sender
// stall
//   when pop stays low the sender holds its token, the queue fills and full
//   rises; bytes are refused until the sender moves again
// ----------------------------------------------------------------------------
module punctuation_and_identifier_lexer import plx_pkg::*; #(
	parameter int POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  text_byte,
	input  logic        final_byte,
	output logic        empty,
	input  logic        pop,
	output logic [3:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic        run_end
);

	// scanner to queue
	logic    f_push;
	bundle_t f_data;
	logic    q_full;

	// queue to sender
	bundle_t q_data;
	logic    q_empty;
	logic    q_pop;

	// front: classifies bytes, tracks colon, minus and identifier lookahead
	plx_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.q_push     (f_push),
		.q_data     (f_data)
	);

	// token groups wait here so the scanner keeps going while the sender stalls
	plx_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (f_push),
		.wr_data (f_data),
		.full    (q_full),
		.pop     (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	// back: one token per request
	plx_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_data       (q_data),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.run_end      (run_end)
	);

	// a byte is refused only while the queue is full
	assign full = q_full;

endmodule
